// ===== hw/rtl/saie_pkg.sv =====
`timescale 1ns / 1ps

package saie_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;

  // item function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
    logic                     load_last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         position;
    logic                     last_of_run;
    logic                     full_error;
  } out_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_INS_START,
    OP_SORT_INIT,
    OP_RD_I,
    OP_KEY,
    OP_RD_JM1,
    OP_SORT_PLACE,
    OP_MOVE,
    OP_SCAN_HIT,
    OP_SCAN_NEXT,
    OP_SHIFT_SET,
    OP_INS_PLACE,
    OP_EMIT,
    OP_ERR
  } dp_op_t;

  typedef struct packed {
    logic full;
    logic i_lt_cnt;
    logic j_zero;
    logic j_eq_pos;
    logic gt;
    logic k_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_INIT,
    ST_SORT_OUTER,
    ST_SORT_KEY,
    ST_SORT_INNER,
    ST_SORT_CMP,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_SHIFT_SET,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_ERR
  } state_t;

endpackage

// ===== hw/rtl/saie_ram.sv =====
`timescale 1ns / 1ps

module saie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/saie_datapath.sv =====
`timescale 1ns / 1ps

module saie_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  saie_pkg::dp_op_t    op,
  input  saie_pkg::in_t       in_item,
  output saie_pkg::dp_status_t status,
  output saie_pkg::out_t      out_item
);

  import saie_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            i_r, i_nxt;
  logic [CW-1:0]            j_r, j_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic [CW-1:0]     jm1;
  logic [EW-1:0]     k_ext;

  assign jm1 = j_r - CW'(1);

  saie_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status toward the controller
  always_comb begin
    status.full     = (cnt_r == CW'(CAPACITY));
    status.i_lt_cnt = (i_r < cnt_r);
    status.j_zero   = (j_r == '0);
    status.j_eq_pos = (j_r == pos_r);
    status.gt       = ($signed(rdata) > key_r);
    status.k_last   = ((i_r + CW'(1)) == cnt_r);
  end

  // memory ports
  always_comb begin
    we    = 1'b0;
    waddr = j_r[AW-1:0];
    wdata = key_r;
    raddr = i_r[AW-1:0];
    case (op)
      OP_LOAD: begin
        we    = !status.full;
        waddr = cnt_r[AW-1:0];
        wdata = in_item.value;
      end
      OP_SORT_PLACE, OP_INS_PLACE: begin
        we = 1'b1;
      end
      OP_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_RD_JM1: begin
        raddr = jm1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // index and count updates
  always_comb begin
    cnt_nxt = cnt_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    pos_nxt = pos_r;
    key_nxt = key_r;
    case (op)
      OP_LOAD:       if (!status.full) cnt_nxt = cnt_r + CW'(1);
      OP_CLEAR:      cnt_nxt = '0;
      OP_INS_START: begin
        key_nxt = in_item.value;
        i_nxt   = '0;
        pos_nxt = cnt_r;
      end
      OP_SORT_INIT:  i_nxt = CW'(1);
      OP_RD_I:       j_nxt = i_r;
      OP_KEY:        key_nxt = $signed(rdata);
      OP_SORT_PLACE: i_nxt = i_r + CW'(1);
      OP_MOVE:       j_nxt = jm1;
      OP_SCAN_HIT:   pos_nxt = i_r;
      OP_SCAN_NEXT:  i_nxt = i_r + CW'(1);
      OP_SHIFT_SET:  j_nxt = cnt_r;
      OP_INS_PLACE: begin
        cnt_nxt = cnt_r + CW'(1);
        i_nxt   = '0;
      end
      OP_EMIT:       i_nxt = i_r + CW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    pos_r <= pos_nxt;
    key_r <= key_nxt;
  end

  // position wraps within its field
  assign k_ext = EW'(i_r);

  always_comb begin
    if (op == OP_ERR) begin
      out_item.element     = '0;
      out_item.position    = '0;
      out_item.last_of_run = 1'b1;
      out_item.full_error  = 1'b1;
    end else begin
      out_item.element     = $signed(rdata);
      out_item.position    = k_ext[POS_W-1:0];
      out_item.last_of_run = status.k_last;
      out_item.full_error  = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/saie_ctrl.sv =====
`timescale 1ns / 1ps

module saie_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           func,
  input  logic                 load_last,
  input  saie_pkg::dp_status_t status,
  output saie_pkg::dp_op_t     op,
  output logic                 busy,
  output logic                 out_strobe
);

  import saie_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op         = OP_NONE;
    out_strobe = 1'b0;
    busy       = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (func)
            FUNC_LOAD: begin
              op = OP_LOAD;
              if (load_last) state_nxt = ST_SORT_INIT;
            end
            FUNC_INSERT: begin
              op        = OP_INS_START;
              state_nxt = status.full ? ST_ERR : ST_SCAN;
            end
            FUNC_CLEAR: op = OP_CLEAR;
            default: begin
            end
          endcase
        end
      end
      ST_SORT_INIT: begin
        op        = OP_SORT_INIT;
        state_nxt = ST_SORT_OUTER;
      end
      ST_SORT_OUTER: begin
        if (status.i_lt_cnt) begin
          op        = OP_RD_I;
          state_nxt = ST_SORT_KEY;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SORT_KEY: begin
        op        = OP_KEY;
        state_nxt = ST_SORT_INNER;
      end
      ST_SORT_INNER: begin
        if (status.j_zero) begin
          op        = OP_SORT_PLACE;
          state_nxt = ST_SORT_OUTER;
        end else begin
          op        = OP_RD_JM1;
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (status.gt) begin
          op        = OP_MOVE;
          state_nxt = ST_SORT_INNER;
        end else begin
          op        = OP_SORT_PLACE;
          state_nxt = ST_SORT_OUTER;
        end
      end
      ST_SCAN: begin
        if (status.i_lt_cnt) begin
          op        = OP_RD_I;
          state_nxt = ST_SCAN_CMP;
        end else begin
          state_nxt = ST_SHIFT_SET;
        end
      end
      ST_SCAN_CMP: begin
        if (status.gt) begin
          op        = OP_SCAN_HIT;
          state_nxt = ST_SHIFT_SET;
        end else begin
          op        = OP_SCAN_NEXT;
          state_nxt = ST_SCAN;
        end
      end
      ST_SHIFT_SET: begin
        op        = OP_SHIFT_SET;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (status.j_eq_pos) begin
          op        = OP_INS_PLACE;
          state_nxt = ST_EMIT_RD;
        end else begin
          op        = OP_RD_JM1;
          state_nxt = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        op        = OP_MOVE;
        state_nxt = ST_SHIFT;
      end
      ST_EMIT_RD: begin
        op        = OP_RD_I;
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        op         = OP_EMIT;
        out_strobe = 1'b1;
        state_nxt  = status.k_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_ERR: begin
        op         = OP_ERR;
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_array_insert_engine_unit.sv =====
`timescale 1ns / 1ps

// sorted store of up to CAPACITY signed 32-bit values, one item at a time.
// an item is taken when start is high and busy is low. a load or a clear
// finishes in the cycle it is taken; a load marked last then runs an
// insertion sort over the held entries. an insert scans for its place,
// shifts the later entries up, then emits the whole store one result at
// a time, with busy high throughout; the pace is set by the single-port
// read of the store memory, whose read data is registered. results appear
// on out_data for exactly one cycle with out_strobe high and cannot be
// held off: the receiver must take every transfer as it comes. an insert
// into a full store gives one result with full_error set and leaves the
// store as it was. entries past the count are never read, so the store
// needs no clearing after reset.

module sorted_array_insert_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  saie_pkg::in_t  in_data,
  output logic           out_strobe,
  output saie_pkg::out_t out_data
);

  import saie_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // sequencer: walks the scan, shift, sort and emit loops
  saie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .func       (in_data.func),
    .load_last  (in_data.load_last),
    .status     (status),
    .op         (op),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // store memory, count, indexes and the one signed comparator
  saie_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_item  (in_data),
    .status   (status),
    .out_item (out_data)
  );

  // a result transfer only happens while an item is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // clear finishes in the cycle it is taken
  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FUNC_CLEAR) |=> !busy)
    else $error("clear did not finish at once");

  // an insert always runs on to at least one result
  a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FUNC_INSERT) |=> busy)
    else $error("insert did not start");

  // the refusal is always the single, final result
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.full_error) |-> (out_data.last_of_run && out_data.position == '0))
    else $error("full error result not marked last");

endmodule
